>>> sv/u2mr_pkg.sv
// u2mr_pkg: shared types, status codes and the MacRoman upper-half table
// for the UTF-8 to MacRoman transcoder. No dependencies.
`timescale 1ns / 1ps

package u2mr_pkg;

  // name buffer size in output bytes, and the output byte counter width
  localparam int NAME_BUF_BYTES = 1024;
  localparam int CNT_W          = $clog2(NAME_BUF_BYTES);

  // status codes reported on the word that closes a name
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_MALFORMED = 2'd1;
  localparam logic [1:0] STAT_UNMAPPED  = 2'd2;
  localparam logic [1:0] STAT_TOO_LONG  = 2'd3;

  // UTF-8 byte class masks and patterns
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] PAT_LEAD2  = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] PAT_LEAD3  = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] PAT_LEAD4  = 8'hF0;
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] PAT_CONT   = 8'h80;

  // table depth and index width
  localparam int ROM_DEPTH = 128;
  localparam int ROM_IDX_W = $clog2(ROM_DEPTH);

  // unicode code points of MacRoman bytes 0x80 to 0xFF
  localparam logic [15:0] ROMAN_HIGH [0:ROM_DEPTH-1] = '{
    16'h00C4, 16'h00C5, 16'h00C7, 16'h00C9, 16'h00D1, 16'h00D6, 16'h00DC, 16'h00E1,
    16'h00E0, 16'h00E2, 16'h00E4, 16'h00E3, 16'h00E5, 16'h00E7, 16'h00E9, 16'h00E8,
    16'h00EA, 16'h00EB, 16'h00ED, 16'h00EC, 16'h00EE, 16'h00EF, 16'h00F1, 16'h00F3,
    16'h00F2, 16'h00F4, 16'h00F6, 16'h00F5, 16'h00FA, 16'h00F9, 16'h00FB, 16'h00FC,
    16'h2020, 16'h00B0, 16'h00A2, 16'h00A3, 16'h00A7, 16'h2022, 16'h00B6, 16'h00DF,
    16'h00AE, 16'h00A9, 16'h2122, 16'h00B4, 16'h00A8, 16'h2260, 16'h00C6, 16'h00D8,
    16'h221E, 16'h00B1, 16'h2264, 16'h2265, 16'h00A5, 16'h00B5, 16'h2202, 16'h2211,
    16'h220F, 16'h03C0, 16'h222B, 16'h00AA, 16'h00BA, 16'h03A9, 16'h00E6, 16'h00F8,
    16'h00BF, 16'h00A1, 16'h00AC, 16'h221A, 16'h0192, 16'h2248, 16'h2206, 16'h00AB,
    16'h00BB, 16'h2026, 16'h00A0, 16'h00C0, 16'h00C3, 16'h00D5, 16'h0152, 16'h0153,
    16'h2013, 16'h2014, 16'h201C, 16'h201D, 16'h2018, 16'h2019, 16'h00F7, 16'h25CA,
    16'h00FF, 16'h0178, 16'h2044, 16'h20AC, 16'h2039, 16'h203A, 16'hFB01, 16'hFB02,
    16'h2021, 16'h00B7, 16'h201A, 16'h201E, 16'h2030, 16'h00C2, 16'h00CA, 16'h00C1,
    16'h00CB, 16'h00C8, 16'h00CD, 16'h00CE, 16'h00CF, 16'h00CC, 16'h00D3, 16'h00D4,
    16'hF8FF, 16'h00D2, 16'h00DA, 16'h00DB, 16'h00D9, 16'h0131, 16'h02C6, 16'h02DC,
    16'h00AF, 16'h02D8, 16'h02D9, 16'h02DA, 16'h00B8, 16'h02DD, 16'h02DB, 16'h02C7
  };

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_RESULT
  } state_t;

  // decoder step result
  typedef struct packed {
    logic        done;
    logic [15:0] code;
  } dec_res_t;

  // commit control from the sequencer to the decoder
  typedef struct packed {
    logic commit;
    logic last;
    logic pass;
    logic done;
    logic found;
  } commit_ctl_t;

  // commit outcome from the decoder
  typedef struct packed {
    logic       emit;
    logic [1:0] status;
  } commit_res_t;

  // table search outcome
  typedef struct packed {
    logic       done;
    logic       hit;
    logic [7:0] mac;
  } srch_res_t;

endpackage

>>> sv/u2mr_search.sv
// u2mr_search: reverse search of the MacRoman upper-half table, one entry
// compared per cycle with a single 16-bit comparator. Depends on u2mr_pkg.
`timescale 1ns / 1ps

module u2mr_search import u2mr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] code,
  output srch_res_t   res
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 hit_r, hit_nxt;
  logic [ROM_IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]          code_r, code_nxt;
  logic                 match;

  // shared compare against the current table entry
  assign match = (ROMAN_HIGH[idx_r] == code_r);

  // scan control
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    hit_nxt  = hit_r;
    idx_nxt  = idx_r;
    code_nxt = code_r;
    if (start) begin
      busy_nxt = 1'b1;
      hit_nxt  = 1'b0;
      idx_nxt  = '0;
      code_nxt = code;
    end else if (busy_r) begin
      if (match || (idx_r == ROM_IDX_W'(ROM_DEPTH - 1))) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        hit_nxt  = match;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      hit_r  <= hit_nxt;
    end
    idx_r  <= idx_nxt;
    code_r <= code_nxt;
  end

  // matching entry index gives the low bits of the MacRoman byte
  assign res.done = done_r;
  assign res.hit  = hit_r;
  assign res.mac  = {1'b1, idx_r};

endmodule

>>> sv/u2mr_decode.sv
// u2mr_decode: UTF-8 decode state, first-error latch and output byte count
// for one name; step on each converted byte, commit when the word resolves.
// Depends on u2mr_pkg.
`timescale 1ns / 1ps

module u2mr_decode import u2mr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  in_data,
  input  commit_ctl_t ctl,
  output dec_res_t    dec,
  output commit_res_t cres
);

  logic [15:0]      partial_r, partial_nxt;
  logic [1:0]       pending_r, pending_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      shifted;
  logic [1:0]       pend_dec;
  logic [1:0]       err_c;

  assign shifted  = {partial_r[9:0], in_data[5:0]};
  assign pend_dec = pending_r - 2'd1;

  // decode step and commit
  always_comb begin
    partial_nxt = partial_r;
    pending_nxt = pending_r;
    err_nxt     = err_r;
    cnt_nxt     = cnt_r;
    dec.done    = 1'b0;
    dec.code    = 16'h0000;
    cres.emit   = 1'b0;
    cres.status = STAT_OK;
    err_c       = err_r;

    // byte decode, only while the name has no error
    if (step && (err_r == STAT_OK)) begin
      if (pending_r == 2'd0) begin
        priority if (!in_data[7]) begin
          dec.done = 1'b1;
          dec.code = {8'h00, in_data};
        end else if ((in_data & MASK_LEAD2) == PAT_LEAD2) begin
          partial_nxt = {11'h000, in_data[4:0]};
          pending_nxt = 2'd1;
        end else if ((in_data & MASK_LEAD3) == PAT_LEAD3) begin
          partial_nxt = {12'h000, in_data[3:0]};
          pending_nxt = 2'd2;
        end else if ((in_data & MASK_LEAD4) == PAT_LEAD4) begin
          err_nxt = STAT_UNMAPPED;
        end else begin
          err_nxt = STAT_MALFORMED;
        end
      end else if ((in_data & MASK_CONT) != PAT_CONT) begin
        err_nxt     = STAT_MALFORMED;
        pending_nxt = 2'd0;
      end else begin
        partial_nxt = shifted;
        pending_nxt = pend_dec;
        if (pend_dec == 2'd0) begin
          dec.done = 1'b1;
          dec.code = shifted;
        end
      end
    end

    // lookup outcome and length check, resolved ahead of the commit strobe
    if (!ctl.pass && ctl.done) begin
      if (!ctl.found) begin
        err_c = STAT_UNMAPPED;
      end else if (cnt_r >= CNT_W'(NAME_BUF_BYTES - 1)) begin
        err_c = STAT_TOO_LONG;
      end else begin
        cres.emit = 1'b1;
      end
    end

    // closing status, a name that ends inside a sequence is malformed
    if (ctl.last) begin
      if ((err_c == STAT_OK) && (pending_r != 2'd0)) begin
        err_c = STAT_MALFORMED;
      end
      cres.status = ctl.pass ? STAT_OK : err_c;
    end

    // commit: latch the error, count the byte, close the name
    if (ctl.commit) begin
      err_nxt = err_c;
      if (cres.emit) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      if (ctl.last) begin
        partial_nxt = '0;
        pending_nxt = '0;
        err_nxt     = STAT_OK;
        cnt_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partial_r <= '0;
      pending_r <= '0;
      err_r     <= STAT_OK;
      cnt_r     <= '0;
    end else begin
      partial_r <= partial_nxt;
      pending_r <= pending_nxt;
      err_r     <= err_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

endmodule

>>> sv/utf8_to_macroman_transcoder_core.sv
// utf8_to_macroman_transcoder_core: top level with sequencer and output word
// register. Depends on u2mr_pkg, u2mr_decode and u2mr_search.
`timescale 1ns / 1ps

// Usage
// - input channel (in_valid/in_ready) takes one UTF-8 byte of a file name per
//   word, in_last marks the final byte of the name
// - output channel (out_valid/out_ready) gives at most one word per input
//   byte; the word for the last byte always comes, with out_last set and
//   out_status holding the first error of the name (0 when clean)
// - cfg_wr_en/cfg_wr_data write convert_enable (reset 1); 0 passes bytes
//   through unchanged; write it only between items
// Timing
// - ASCII, pass-through and non-completing bytes: idle, then result state
// - a completed character at or above 0x80 adds a reverse search of the
//   128-entry table, one entry per cycle on a single 16-bit comparator,
//   in the search state between the idle and result states
// - one byte in flight at a time; in_ready is high only while idle
// Reset clears the sequencer, decode state and output register and sets
// convert_enable. When the receiver stalls the word waits in the output
// register; the next byte is still accepted, and its own word then waits
// in the sequencer until the register frees.

module utf8_to_macroman_transcoder_core import u2mr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_has_byte,
  output logic [7:0] out_mac_byte,
  output logic       out_last,
  output logic [1:0] out_status
);

  state_t      state_r, state_nxt;
  logic        conv_en_r;
  logic        accept;
  logic        step;
  logic        srch_start;
  dec_res_t    dec;
  commit_ctl_t ctl;
  commit_res_t cres;
  srch_res_t   srch;

  // latched item
  logic [7:0]  data_r;
  logic        last_r;
  logic        pass_r;
  logic        done_r;
  logic [15:0] code_r;
  logic        need_srch_r;

  // output word register
  logic        ov_r, ov_nxt;
  logic        has_r;
  logic [7:0]  mac_r;
  logic        olast_r;
  logic [1:0]  stat_r;
  logic        slot_free;
  logic        has_out;
  logic        load;
  logic [7:0]  mac_val;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      conv_en_r <= cfg_wr_data;
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign step       = accept && conv_en_r;
  assign srch_start = step && dec.done && (dec.code[15:7] != 9'd0);
  assign slot_free  = !ov_r || out_ready;

  // resolve the word in the result state
  assign mac_val = need_srch_r ? srch.mac : code_r[7:0];
  assign has_out = pass_r || last_r || cres.emit;

  always_comb begin
    ctl.commit = 1'b0;
    ctl.last   = last_r;
    ctl.pass   = pass_r;
    ctl.done   = done_r;
    ctl.found  = need_srch_r ? srch.hit : 1'b1;
    load       = 1'b0;
    state_nxt  = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = srch_start ? S_SEARCH : S_RESULT;
        end
      end
      S_SEARCH: begin
        if (srch.done) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        // emit decision is independent of the commit strobe
        ctl.commit = !has_out || slot_free;
        load       = has_out && slot_free;
        if (ctl.commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (accept) begin
      data_r      <= in_byte;
      last_r      <= in_last;
      pass_r      <= !conv_en_r;
      done_r      <= dec.done;
      code_r      <= dec.code;
      need_srch_r <= srch_start;
    end
  end

  // output word register
  always_comb begin
    ov_nxt = ov_r;
    if (load) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
    if (load) begin
      has_r   <= pass_r || cres.emit;
      mac_r   <= pass_r ? data_r : (cres.emit ? mac_val : 8'h00);
      olast_r <= last_r;
      stat_r  <= cres.status;
    end
  end

  assign out_valid    = ov_r;
  assign out_has_byte = has_r;
  assign out_mac_byte = mac_r;
  assign out_last     = olast_r;
  assign out_status   = stat_r;

  // name decode state
  u2mr_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_data (in_byte),
    .ctl     (ctl),
    .dec     (dec),
    .cres    (cres)
  );

  // table search unit
  u2mr_search u_search (
    .clk   (clk),
    .rst_n (rst_n),
    .start (srch_start),
    .code  (dec.code),
    .res   (srch)
  );

`ifndef SYNTHESIS
  // errors are only reported on the word that closes a name
  a_status_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_OK) |-> out_last)
    else $error("error status on a word that does not close the name");

  // a word without a character is always the closing word, with a zero byte
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_last && (out_mac_byte == 8'h00))
    else $error("empty word that does not close the name");

  // the search only finishes while the sequencer waits for it
  a_search_done: assert property (@(posedge clk) disable iff (!rst_n)
    srch.done |-> (state_r == S_SEARCH))
    else $error("search finished outside the search state");

  // a search starts only on an accepted byte in convert mode
  a_search_start: assert property (@(posedge clk) disable iff (!rst_n)
    srch_start |-> accept && conv_en_r)
    else $error("search started without an accepted byte");
`endif

endmodule
